// ----- sv/twap_pkg.sv -----
package twap_pkg;

  localparam int SAMPLE_W = 24;
  localparam int TIME_W   = 32;
  localparam int PEAK_W   = 23;
  localparam int SFILL_W  = 7;
  localparam int LFILL_W  = 11;
  localparam int DIVD_W   = 57;
  localparam int DIVS_W   = 32;
  localparam int ENTRY_W  = SAMPLE_W + TIME_W;

  localparam int SHORT_DEPTH_DEF = 64;
  localparam int LONG_DEPTH_DEF  = 1024;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic [TIME_W-1:0] SHORT_WINDOW_RST = 32'd1000;
  localparam logic [TIME_W-1:0] LONG_WINDOW_RST  = 32'd60000;

  localparam logic REG_SHORT_WINDOW = 1'b0;
  localparam logic REG_LONG_WINDOW  = 1'b1;

endpackage

// ----- sv/twap_in_if.sv -----
interface twap_in_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [twap_pkg::SAMPLE_W-1:0]   sample;
  logic        [twap_pkg::TIME_W-1:0]     time_ms;

  modport source (output valid, output sample, output time_ms, input ready);
  modport sink   (input valid, input sample, input time_ms, output ready);
endinterface

// ----- sv/twap_out_if.sv -----
interface twap_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [twap_pkg::SAMPLE_W-1:0]   short_mean;
  logic signed [twap_pkg::SAMPLE_W-1:0]   long_mean;
  logic signed [twap_pkg::SAMPLE_W-1:0]   overall_mean;
  logic        [twap_pkg::PEAK_W-1:0]     peak_value;
  logic        [twap_pkg::SFILL_W-1:0]    short_fill;
  logic        [twap_pkg::LFILL_W-1:0]    long_fill;

  modport source (output valid, output short_mean, output long_mean, output overall_mean,
                  output peak_value, output short_fill, output long_fill, input ready);
  modport sink   (input valid, input short_mean, input long_mean, input overall_mean,
                  input peak_value, input short_fill, input long_fill, output ready);
endinterface

// ----- sv/twap_ram.sv -----
module twap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ----- sv/twap_win.sv -----
module twap_win #(
  parameter int DEPTH = twap_pkg::SHORT_DEPTH_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic        [twap_pkg::TIME_W-1:0]   limit,
  input  logic signed [twap_pkg::SAMPLE_W-1:0] x,
  input  logic        [twap_pkg::TIME_W-1:0]   now,
  output logic                                 busy,
  output logic signed [twap_pkg::DIVD_W-1:0]   sum,
  output logic        [twap_pkg::DIVS_W-1:0]   count
);

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = AW + 2;
  localparam int DW = twap_pkg::DIVD_W;
  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
  localparam logic [PW-1:0] DEPTH_P = PW'(DEPTH);
  localparam logic [AW-1:0] LAST_A  = AW'(DEPTH - 1);

  typedef enum logic [1:0] {IDLE, SCAN, WRITE} state_t;

  state_t                  state;
  logic [AW-1:0]           head;
  logic [CW-1:0]           cnt;
  logic [CW-1:0]           rem;
  logic [CW-1:0]           kept;
  logic [AW-1:0]           ptr;
  logic                    rvalid;
  logic signed [DW-1:0]    acc;

  logic                    ram_we;
  logic [AW-1:0]           ram_addr;
  logic [twap_pkg::ENTRY_W-1:0] ram_wdata;
  logic [twap_pkg::ENTRY_W-1:0] ram_rdata;
  logic signed [twap_pkg::SAMPLE_W-1:0] rval;
  logic [twap_pkg::TIME_W-1:0] rstamp;
  logic [twap_pkg::TIME_W-1:0] age;
  logic                    keep;
  logic                    full;
  logic [PW-1:0]           first_raw;
  logic [PW-1:0]           first_wrap;
  logic [AW-1:0]           ptr_inc;
  logic [AW-1:0]           head_inc;

  twap_ram #(.WIDTH(twap_pkg::ENTRY_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_comb begin
    ram_we     = (state == WRITE);
    ram_addr   = (state == WRITE) ? head : ptr;
    ram_wdata  = {x, now};
    rval       = ram_rdata[twap_pkg::ENTRY_W-1:twap_pkg::TIME_W];
    rstamp     = ram_rdata[twap_pkg::TIME_W-1:0];
    age        = now - rstamp;
    keep       = rvalid && (age < limit);
    full       = (cnt == DEPTH_C);
    first_raw  = PW'(head) + DEPTH_P - PW'(cnt) + PW'(full);
    first_wrap = (first_raw >= DEPTH_P) ? (first_raw - DEPTH_P) : first_raw;
    ptr_inc    = (ptr == LAST_A) ? '0 : ptr + 1'b1;
    head_inc   = (head == LAST_A) ? '0 : head + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= IDLE;
      head   <= '0;
      cnt    <= '0;
      rvalid <= 1'b0;
    end else begin
      rvalid <= 1'b0;
      if (keep) begin
        acc  <= acc + DW'(rval);
        kept <= kept + 1'b1;
      end
      unique case (state)
        IDLE: begin
          if (start) begin
            rem   <= full ? cnt - 1'b1 : cnt;
            ptr   <= first_wrap[AW-1:0];
            acc   <= '0;
            kept  <= '0;
            state <= SCAN;
          end
        end
        SCAN: begin
          if (rem != '0) begin
            rvalid <= 1'b1;
            ptr    <= ptr_inc;
            rem    <= rem - 1'b1;
          end else begin
            state <= WRITE;
          end
        end
        WRITE: begin
          acc   <= acc + DW'(x);
          cnt   <= kept + 1'b1;
          head  <= head_inc;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign busy  = (state != IDLE);
  assign sum   = acc;
  assign count = twap_pkg::DIVS_W'(cnt);

endmodule

// ----- sv/twap_div.sv -----
module twap_div (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [twap_pkg::DIVD_W-1:0]   dividend,
  input  logic        [twap_pkg::DIVS_W-1:0]   divisor,
  output logic                                 busy,
  output logic signed [twap_pkg::SAMPLE_W-1:0] quot
);

  localparam int DW = twap_pkg::DIVD_W;
  localparam int SW = twap_pkg::DIVS_W;
  localparam int NW = $clog2(DW + 1);

  logic          running;
  logic [NW-1:0] steps;
  logic          neg;
  logic [DW-1:0] dq;
  logic [SW:0]   rem;
  logic [SW-1:0] dsr;
  logic [SW:0]   trial;
  logic          fits;
  logic [twap_pkg::SAMPLE_W-1:0] qmag;

  always_comb begin
    trial = {rem[SW-1:0], dq[DW-1]};
    fits  = (trial >= {1'b0, dsr});
    qmag  = dq[twap_pkg::SAMPLE_W-1:0];
    quot  = neg ? -$signed(qmag) : $signed(qmag);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
    end else if (start) begin
      running <= 1'b1;
      steps   <= NW'(DW);
      neg     <= dividend[DW-1];
      dq      <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem     <= '0;
      dsr     <= divisor;
    end else if (running) begin
      rem   <= fits ? trial - {1'b0, dsr} : trial;
      dq    <= {dq[DW-2:0], fits};
      steps <= steps - 1'b1;
      if (steps == NW'(1)) begin
        running <= 1'b0;
      end
    end
  end

  assign busy = running;

endmodule

// ----- sv/timed_window_average_peak_top.sv -----
// Each accepted word is processed in order: both rings are scanned in parallel, one entry
// a cycle through each ring's RAM port, for the larger of the two rings' scan lengths (the
// fill, or one less for a full ring); then one shared divider runs three passes. A new
// word is accepted only once the previous result has been placed on the output.
// Synchronous reset clears heads, fills, running mean, sample count and peak; the
// ring RAMs are not cleared.
module timed_window_average_peak_top #(
  parameter int SHORT_DEPTH = twap_pkg::SHORT_DEPTH_DEF,
  parameter int LONG_DEPTH  = twap_pkg::LONG_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  twap_in_if.sink                       in_ch,
  twap_out_if.source                    out_ch,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [twap_pkg::PADDR_W-1:0]  paddr,
  input  logic [twap_pkg::PDATA_W-1:0]  pwdata,
  output logic [twap_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  localparam int DW = twap_pkg::DIVD_W;
  localparam int XW = twap_pkg::SAMPLE_W;
  localparam int TW = twap_pkg::TIME_W;

  typedef enum logic [2:0] {IDLE, WIN, MUL, DIV, DWAIT, DONE} state_t;
  typedef enum logic [1:0] {OP_SHORT, OP_LONG, OP_ALL} op_t;

  state_t               state;
  op_t                  sel;
  logic [TW-1:0]        short_window;
  logic [TW-1:0]        long_window;
  logic signed [XW-1:0] x;
  logic [TW-1:0]        now;
  logic [TW-1:0]        total;
  logic signed [XW-1:0] rmean;
  logic [twap_pkg::PEAK_W-1:0] peak;
  logic signed [DW-1:0] prod;
  logic signed [XW-1:0] q_short;
  logic signed [XW-1:0] q_long;

  logic                 accept;
  logic                 s_busy;
  logic                 l_busy;
  logic signed [DW-1:0] s_sum;
  logic signed [DW-1:0] l_sum;
  logic [31:0]          s_cnt;
  logic [31:0]          l_cnt;
  logic                 div_start;
  logic signed [DW-1:0] div_a;
  logic [31:0]          div_b;
  logic                 div_busy;
  logic signed [XW-1:0] div_q;
  logic [twap_pkg::PEAK_W-1:0] peak_next;
  logic                 cfg_wr;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state == IDLE);
  assign pready       = 1'b1;
  assign cfg_wr       = psel && penable && pwrite;
  assign prdata       = (paddr[2] == twap_pkg::REG_LONG_WINDOW) ? long_window : short_window;

  twap_win #(.DEPTH(SHORT_DEPTH)) u_short (
    .clk(clk), .rst(rst), .start(accept), .limit(short_window),
    .x(x), .now(now), .busy(s_busy), .sum(s_sum), .count(s_cnt)
  );

  twap_win #(.DEPTH(LONG_DEPTH)) u_long (
    .clk(clk), .rst(rst), .start(accept), .limit(long_window),
    .x(x), .now(now), .busy(l_busy), .sum(l_sum), .count(l_cnt)
  );

  twap_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_a), .divisor(div_b),
    .busy(div_busy), .quot(div_q)
  );

  always_comb begin
    div_start = (state == DIV);
    unique case (sel)
      OP_SHORT: begin div_a = s_sum; div_b = s_cnt; end
      OP_LONG:  begin div_a = l_sum; div_b = l_cnt; end
      OP_ALL:   begin div_a = prod;  div_b = total; end
      default:  begin div_a = prod;  div_b = total; end
    endcase
    peak_next = (!x[XW-1] && (x[twap_pkg::PEAK_W-1:0] > peak)) ?
                x[twap_pkg::PEAK_W-1:0] : peak;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      short_window <= twap_pkg::SHORT_WINDOW_RST;
      long_window  <= twap_pkg::LONG_WINDOW_RST;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        twap_pkg::REG_SHORT_WINDOW: short_window <= pwdata;
        twap_pkg::REG_LONG_WINDOW:  long_window  <= pwdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= IDLE;
      sel          <= OP_SHORT;
      total        <= '0;
      rmean        <= '0;
      peak         <= '0;
      out_ch.valid <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready && state != DONE) begin
        out_ch.valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            x     <= in_ch.sample;
            now   <= in_ch.time_ms;
            total <= (total == '1) ? total : total + 1'b1;
            state <= WIN;
          end
        end
        WIN: begin
          if (!s_busy && !l_busy) begin
            state <= MUL;
          end
        end
        MUL: begin
          prod  <= DW'(rmean * $signed({1'b0, total - 1'b1})) + DW'(x);
          sel   <= OP_SHORT;
          state <= DIV;
        end
        DIV: begin
          state <= DWAIT;
        end
        DWAIT: begin
          if (!div_busy) begin
            unique case (sel)
              OP_SHORT: begin q_short <= div_q; sel <= OP_LONG; state <= DIV; end
              OP_LONG:  begin q_long  <= div_q; sel <= OP_ALL;  state <= DIV; end
              default:  begin rmean   <= div_q; state <= DONE; end
            endcase
          end
        end
        DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid        <= 1'b1;
            out_ch.short_mean   <= q_short;
            out_ch.long_mean    <= q_long;
            out_ch.overall_mean <= rmean;
            out_ch.peak_value   <= peak_next;
            out_ch.short_fill   <= s_cnt[twap_pkg::SFILL_W-1:0];
            out_ch.long_fill    <= l_cnt[twap_pkg::LFILL_W-1:0];
            peak                <= peak_next;
            state               <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- test/tb_top.sv -----
module tb_top;

  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [twap_pkg::SAMPLE_W-1:0] short_mean;
    logic signed [twap_pkg::SAMPLE_W-1:0] long_mean;
    logic signed [twap_pkg::SAMPLE_W-1:0] overall_mean;
    logic [twap_pkg::PEAK_W-1:0]          peak_value;
    logic [twap_pkg::SFILL_W-1:0]         short_fill;
    logic [twap_pkg::LFILL_W-1:0]         long_fill;
  } stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [twap_pkg::PADDR_W-1:0] paddr = '0;
  logic [twap_pkg::PDATA_W-1:0] pwdata = '0;
  logic [twap_pkg::PDATA_W-1:0] prdata;
  logic pready;

  twap_in_if  in_ch ();
  twap_out_if out_ch ();

  timed_window_average_peak_top dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Model state of the two rings and the all-time statistics.
  int          short_vals[twap_pkg::LONG_DEPTH_DEF];
  int unsigned short_stamps[twap_pkg::LONG_DEPTH_DEF];
  int          long_vals[twap_pkg::LONG_DEPTH_DEF];
  int unsigned long_stamps[twap_pkg::LONG_DEPTH_DEF];
  int          short_head, short_count, long_head, long_count;
  longint      overall_avg;
  longint      seen_total;
  int          peak_so_far;
  logic [twap_pkg::TIME_W-1:0] short_limit, long_limit;

  stats_t pending_stats[$];
  int     fail_count = 0;
  bit     hold_off = 1'b0;
  bit     stall_random = 1'b0;
  logic [twap_pkg::TIME_W-1:0] clock_ms = '0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.sample = '0;
    in_ch.time_ms = '0;
    out_ch.ready = 1'b0;
  end

  task automatic ring_update(ref int vals[twap_pkg::LONG_DEPTH_DEF],
                             ref int unsigned stamps[twap_pkg::LONG_DEPTH_DEF],
                             input int depth, ref int head, ref int count,
                             input logic [twap_pkg::TIME_W-1:0] limit, input int x,
                             input logic [twap_pkg::TIME_W-1:0] now, output longint mean);
    longint sum;
    int kept;
    int first;
    int idx;
    logic [twap_pkg::TIME_W-1:0] age;
    sum = 0;
    kept = 0;
    first = (count == depth) ? 1 : 0;
    for (int i = first; i < count; i++) begin
      idx = (head + depth - count + i) % depth;
      age = now - stamps[idx];
      if (age < limit) begin
        sum += vals[idx];
        kept++;
      end
    end
    vals[head] = x;
    stamps[head] = now;
    sum += x;
    kept++;
    count = kept;
    head = (head + 1) % depth;
    mean = sum / kept;
  endtask

  task automatic predict_window_stats(input logic signed [twap_pkg::SAMPLE_W-1:0] s,
                                      input logic [twap_pkg::TIME_W-1:0] now);
    stats_t r;
    longint sm, lm, acc;
    int x;
    x = s;
    ring_update(short_vals, short_stamps, twap_pkg::SHORT_DEPTH_DEF, short_head,
                short_count, short_limit, x, now, sm);
    ring_update(long_vals, long_stamps, twap_pkg::LONG_DEPTH_DEF, long_head,
                long_count, long_limit, x, now, lm);
    if (seen_total != 64'hFFFF_FFFF) seen_total++;
    acc = overall_avg * (seen_total - 1) + x;
    overall_avg = acc / seen_total;
    if (x > peak_so_far) peak_so_far = x;
    r.short_mean = sm[twap_pkg::SAMPLE_W-1:0];
    r.long_mean = lm[twap_pkg::SAMPLE_W-1:0];
    r.overall_mean = overall_avg[twap_pkg::SAMPLE_W-1:0];
    r.peak_value = peak_so_far[twap_pkg::PEAK_W-1:0];
    r.short_fill = short_count[twap_pkg::SFILL_W-1:0];
    r.long_fill = long_count[twap_pkg::LFILL_W-1:0];
    pending_stats.push_back(r);
  endtask

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  // Offers one word and returns once it is accepted; valid stays high.
  task automatic send_word(input logic signed [twap_pkg::SAMPLE_W-1:0] s,
                           input logic [twap_pkg::TIME_W-1:0] now);
    in_ch.valid <= 1'b1;
    in_ch.sample <= s;
    in_ch.time_ms <= now;
    do @(posedge clk); while (!in_ch.ready);
    predict_window_stats(s, now);
  endtask

  task automatic idle_gap(input int n);
    in_ch.valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain();
    idle_gap(1);
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [twap_pkg::TIME_W-1:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == twap_pkg::REG_SHORT_WINDOW) short_limit = value;
    else long_limit = value;
  endtask

  // Random words in bursts: mostly rising timestamps, sometimes a jump anywhere.
  task automatic send_random(input int count, input int max_step);
    int burst;
    logic signed [twap_pkg::SAMPLE_W-1:0] s;
    burst = $urandom_range(1, 8);
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 9))
        0: s = {1'b1, 23'd0};
        1: s = {1'b0, {23{1'b1}}};
        2: s = twap_pkg::SAMPLE_W'($urandom_range(0, 100));
        default: s = twap_pkg::SAMPLE_W'($urandom);
      endcase
      if ($urandom_range(0, 19) == 0) clock_ms = $urandom;
      else clock_ms = clock_ms + $urandom_range(0, max_step);
      send_word(s, clock_ms);
      burst--;
      if (burst == 0) begin
        burst = $urandom_range(1, 8);
        if ($urandom_range(0, 3) != 0) idle_gap($urandom_range(1, 300));
      end
    end
  endtask

  task automatic test_directed();
    stall_random = 1'b0;
    clock_ms = 32'd100;
    send_word({1'b0, {23{1'b1}}}, clock_ms);
    send_word({1'b1, 23'd0}, clock_ms + 1);
    send_word(24'sd0, clock_ms + 2);
    send_word(-24'sd1, clock_ms + 3);
    send_word(24'sd1, clock_ms + 999);
    send_word(24'sd7, clock_ms + 1003);
    send_word({1'b0, {23{1'b1}}}, clock_ms + 1003);
    send_word(24'sd5, 32'hFFFF_FFF0);
    send_word(-24'sd9, 32'h0000_0005);
    send_word({1'b1, 23'd0}, 32'h0000_03F0);
    send_word(24'sd3, 32'h0001_0000);
    clock_ms = 32'h0001_0000;
    drain();
  endtask

  task automatic test_window_settings();
    stall_random = 1'b1;
    write_reg(twap_pkg::REG_SHORT_WINDOW, 32'd1);
    write_reg(twap_pkg::REG_LONG_WINDOW, 32'hFFFF_FFFF);
    send_random(70, 3);
    write_reg(twap_pkg::REG_SHORT_WINDOW, 32'hFFFF_FFFF);
    write_reg(twap_pkg::REG_LONG_WINDOW, 32'd1);
    send_random(70, 3);
    write_reg(twap_pkg::REG_SHORT_WINDOW, 32'd50);
    write_reg(twap_pkg::REG_LONG_WINDOW, 32'd500);
    send_random(90, 20);
    drain();
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (4000) @(posedge clk);
        hold_off = 1'b0;
      end
      send_random(40, 30);
    join
    drain();
    send_random(60, 30);
    drain();
  endtask

  // Neither window ages out, so the short ring fills and wraps.
  task automatic test_ring_full();
    write_reg(twap_pkg::REG_SHORT_WINDOW, 32'hFFFF_FFFF);
    write_reg(twap_pkg::REG_LONG_WINDOW, 32'hFFFF_FFFF);
    stall_random = 1'b0;
    for (int i = 0; i < 80; i++) begin
      clock_ms = clock_ms + $urandom_range(0, 40);
      send_word(twap_pkg::SAMPLE_W'($urandom), clock_ms);
    end
    drain();
  endtask

  always @(posedge clk) begin
    if (hold_off) out_ch.ready <= 1'b0;
    else if (stall_random) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= 1'b1;
  end

  always @(posedge clk) begin
    stats_t w;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (pending_stats.size() == 0) begin
        report("unexpected word", 0, 0);
      end else begin
        w = pending_stats.pop_front();
        if (out_ch.short_mean !== w.short_mean)
          report("short_mean", out_ch.short_mean, w.short_mean);
        if (out_ch.long_mean !== w.long_mean)
          report("long_mean", out_ch.long_mean, w.long_mean);
        if (out_ch.overall_mean !== w.overall_mean)
          report("overall_mean", out_ch.overall_mean, w.overall_mean);
        if (out_ch.peak_value !== w.peak_value)
          report("peak_value", out_ch.peak_value, w.peak_value);
        if (out_ch.short_fill !== w.short_fill)
          report("short_fill", out_ch.short_fill, w.short_fill);
        if (out_ch.long_fill !== w.long_fill)
          report("long_fill", out_ch.long_fill, w.long_fill);
      end
    end
  end

  initial begin
    #300ms;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    short_head = 0;
    short_count = 0;
    long_head = 0;
    long_count = 0;
    overall_avg = 0;
    seen_total = 0;
    peak_so_far = 0;
    short_limit = twap_pkg::SHORT_WINDOW_RST;
    long_limit = twap_pkg::LONG_WINDOW_RST;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_window_settings();
    test_backpressure();
    test_ring_full();
    drain();
    repeat (1300) @(posedge clk);
    if (fail_count == 0 && pending_stats.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

// ----- files.f -----
sv/twap_pkg.sv
sv/twap_in_if.sv
sv/twap_out_if.sv
sv/twap_ram.sv
sv/twap_win.sv
sv/twap_div.sv
sv/timed_window_average_peak_top.sv
test/tb_top.sv
